/* rtl/sha256_byte_stream_hasher_macros.svh */
// Assertion helpers for the hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH
// Check that a condition implies a result in the same cycle.
`define SHA_ASSERT_IMP(label, clk, rst_n, cond, res, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (res)) \
		else $error(msg);
// Check that a condition implies a result in the next cycle.
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, res, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
		else $error(msg);
`endif

/* rtl/sha256_pkg.sv */
`timescale 1ns / 1ps
package sha256_pkg;
	localparam int unsigned QDepth = 4;
	localparam int unsigned QAw = 2;

	typedef enum logic {
		OP_ABSORB = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	// Queue entry between the front and the back.
	typedef struct packed {
		logic       finish;
		logic [7:0] data;
	} cmd_t;

	typedef logic [31:0] word_t;

	function automatic word_t round_const(input logic [5:0] idx);
		word_t k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
			32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
			32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
			32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
			32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
			32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
			32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
			32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
			32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[idx];
	endfunction

	function automatic word_t init_hash(input logic [2:0] idx);
		word_t h [8];
		h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		return h[idx];
	endfunction
endpackage

/* rtl/sha256_if.sv */
`timescale 1ns / 1ps
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] data_byte;
	modport source (output valid, opcode, data_byte, input ready);
	modport sink (input valid, opcode, data_byte, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/sha256_front.sv */
`timescale 1ns / 1ps
module sha256_front (
	input  logic                clk,
	input  logic                arst_n,
	sha256_in_if.sink           in_ch,
	output sha256_pkg::cmd_t    cmd,
	output logic                cmd_valid,
	input  logic                cmd_pop
);
	import sha256_pkg::*;

	cmd_t           mem_q [QDepth];
	logic [QAw-1:0] wr_q;
	logic [QAw-1:0] rd_q;
	logic [QAw:0]   cnt_q;
	logic           push;

	assign in_ch.ready = (cnt_q != QAw'(0) + (QAw+1)'(QDepth));
	assign push        = in_ch.valid && in_ch.ready;
	assign cmd_valid   = (cnt_q != '0);
	assign cmd         = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q].finish <= (in_ch.opcode == OP_FINISH);
			mem_q[wr_q].data   <= in_ch.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (cmd_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QAw+1)'(push) - (QAw+1)'(cmd_pop);
		end
	end
endmodule

/* rtl/sha256_core.sv */
`timescale 1ns / 1ps
module sha256_core (
	input  logic             clk,
	input  logic             arst_n,
	input  sha256_pkg::cmd_t cmd,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	sha256_out_if.source     out_ch
);
	import sha256_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_COMP  = 6'b000100,
		ST_FOLD  = 6'b001000,
		ST_EMIT  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t      state_q;
	word_t       blk_q [16]; // block buffer, big-endian words
	logic [5:0]  fill_q;
	logic [60:0] total_q;
	word_t       h_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [5:0]  rnd_q;
	logic        final_q;   // write 0x80 as the next pad byte
	logic        second_q;  // finish needs one more block
	logic        pad_done_q;
	logic [2:0]  idx_q;

	word_t w_cur, s0, s1, t1, t2, w_new;
	logic [63:0] bits;
	logic [4:0]  lane;

	assign bits = {total_q, 3'b000};
	// Byte 0 of a word sits in its top lane.
	assign lane = {~fill_q[1:0], 3'b000};
	assign w_cur = (rnd_q < 6'd16) ? blk_q[rnd_q[3:0]] : w_new;
	assign s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
	assign s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
		^ (w_q[14] >> 10);
	assign w_new = w_q[0] + s0 + w_q[9] + s1;
	assign t1 = v_q[7] + ({v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
		^ {v_q[4][24:0], v_q[4][31:25]}) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ round_const(rnd_q) + w_cur;
	assign t2 = ({v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
		^ {v_q[0][21:0], v_q[0][31:22]})
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign out_ch.valid       = (state_q == ST_EMIT);
	assign out_ch.digest_word = h_q[idx_q];
	assign out_ch.word_index  = idx_q;
	assign out_ch.last_word   = (idx_q == 3'd7);

	// Buffer writes: absorb, padding fill; round shifts of schedule and working words.
	always_ff @(posedge clk) begin
		if (cmd_pop && !cmd.finish) begin
			blk_q[fill_q[5:2]][lane +: 8] <= cmd.data;
		end else if (state_q == ST_PAD) begin
			if (fill_q >= 6'd56 && !second_q)
				blk_q[fill_q[5:2]][lane +: 8] <= bits[{~fill_q[2:0], 3'b000} +: 8];
			else
				blk_q[fill_q[5:2]][lane +: 8] <= (final_q) ? 8'h80 : 8'h00;
		end
		if (state_q == ST_COMP) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_cur;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
	end

	// final_q here marks "write 0x80 next pad byte"; second_q marks first of two blocks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			total_q  <= '0;
			rnd_q    <= '0;
			final_q  <= 1'b0;
			second_q <= 1'b0;
			idx_q    <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (cmd.finish) begin
							final_q  <= 1'b1;
							second_q <= (fill_q >= 6'd56);
							state_q  <= ST_PAD;
						end else begin
							total_q <= total_q + 61'd1;
							fill_q  <= fill_q + 6'd1;
							if (fill_q == 6'd63) begin
								rnd_q   <= '0;
								state_q <= ST_COMP;
							end
						end
					end
				end
				ST_PAD: begin
					final_q <= 1'b0;
					fill_q  <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						rnd_q   <= '0;
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					idx_q <= '0;
					if (second_q) begin
						second_q <= 1'b0;
						state_q  <= ST_PAD;
					end else if (pad_done_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_ch.ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
					total_q <= '0;
					fill_q  <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Set from the finish pop until the digest is out, so the fold knows to emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pad_done_q <= 1'b0;
		else if (state_q == ST_IDLE && cmd_pop && cmd.finish) pad_done_q <= 1'b1;
		else if (state_q == ST_DONE) pad_done_q <= 1'b0;
	end
endmodule

/* rtl/sha256_byte_stream_hasher.sv */
`timescale 1ns / 1ps
// SHA-256 over a byte stream. Each input beat absorbs one byte (opcode 0)
// or finishes the message (opcode 1); a finish yields eight output beats,
// digest word 0 first, last_word set on word 7, then the engine restarts
// from the standard initial hash. A four-entry queue decouples the input
// from the compression engine. Every 64th byte starts a compression (one
// round per cycle plus a fold). Finish takes the beat, then runs the
// padding fill (one or two blocks), a compression for each of them, eight
// output beats (longer under output stalls) and the restore of the
// initial hash.
`include "sha256_byte_stream_hasher_macros.svh"
module sha256_byte_stream_hasher (
	input  logic         clk,
	input  logic         arst_n,
	sha256_in_if.sink    in_ch,
	sha256_out_if.source out_ch
);
	import sha256_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	// Front: accept and queue beats.
	sha256_front u_front (
		.clk, .arst_n, .in_ch, .cmd, .cmd_valid, .cmd_pop
	);

	// Back: buffer, pad, compress, emit.
	sha256_core u_core (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_pop, .out_ch
	);

	`SHA_ASSERT_IMP(a_pop_valid, clk, arst_n, cmd_pop, cmd_valid, "pop from empty queue")
	`SHA_ASSERT_NEXT(a_last_wraps, clk, arst_n,
		out_ch.valid && out_ch.ready && out_ch.last_word, !out_ch.valid,
		"output continued after last word")
endmodule
